FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at each rising clock edge, held off while reset is high.
`define TCMS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check a property at each rising clock edge, reset included.
`define TCMS_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`else

`define TCMS_ASSERT(label, clk, rst, prop)
`define TCMS_ASSERT_NR(label, clk, prop)

`endif

`endif

FILE: rtl/core/tcms_pkg.sv
package tcms_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   // |query - centre| needs one bit more than a word; a sum of two squares
   // of that needs two more than twice a word.
   localparam int DIFF_BITS = WORD_BITS + 1;
   localparam int SQ_BITS   = 2 * DIFF_BITS;
   localparam int ROOT_BITS = DIFF_BITS;

   localparam int SQRT_STAGES = ROOT_BITS;
   localparam int DIV_STAGES  = FRAC_BITS;

   // Blend weight runs from 0 to 1.0 inclusive.
   localparam int FX_BITS   = FRAC_BITS + 1;
   localparam int PROD_BITS = WORD_BITS + FX_BITS;

   // difference, square, sum, root digits, edge distance, quotient digits,
   // t^2, t^3, weight, products, blend
   localparam int LANE_STAGES = SQRT_STAGES + DIV_STAGES + 9;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int HALF_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEFAULT_SIZE       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTCH_CENTER       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTCH_RADIUS_REACH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTCH_SIZE         = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLE_CENTER        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLE_RADIUS_REACH  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLE_SIZE          = 3'd6;
   // index with no register behind it
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX       = 3'd7;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] cx;
      logic signed [WORD_BITS-1:0] cy;
      logic [WORD_BITS-1:0]        radius;
      logic [WORD_BITS-1:0]        reach;
      logic [WORD_BITS-1:0]        size;
   } circle_cfg_type;

endpackage

FILE: rtl/core/tcms_circle.sv
module tcms_circle (
   input  logic                                   clock,
   input  logic                                   advance,
   input  tcms_pkg::circle_cfg_type               cfg,
   input  logic [tcms_pkg::WORD_BITS-1:0]         dflt,
   input  logic signed [tcms_pkg::WORD_BITS-1:0]  qx,
   input  logic signed [tcms_pkg::WORD_BITS-1:0]  qy,
   output logic [tcms_pkg::WORD_BITS-1:0]         blend
);

   localparam int W  = tcms_pkg::WORD_BITS;
   localparam int F  = tcms_pkg::FRAC_BITS;
   localparam int DB = tcms_pkg::DIFF_BITS;
   localparam int SB = tcms_pkg::SQ_BITS;
   localparam int RB = tcms_pkg::ROOT_BITS;
   localparam int NS = tcms_pkg::SQRT_STAGES;
   localparam int ND = tcms_pkg::DIV_STAGES;
   localparam int XB = tcms_pkg::FX_BITS;
   localparam int PB = tcms_pkg::PROD_BITS;
   localparam logic [XB-1:0] ONE = XB'(1) << F;

   // distance to the centre
   logic [DB-1:0] diff_x, diff_y, dx_in, dy_in;
   logic [DB-1:0] dx_ff, dy_ff;
   logic [SB-1:0] sqx_ff, sqy_ff, sum_ff;

   assign diff_x = {qx[W-1], qx} - {cfg.cx[W-1], cfg.cx};
   assign diff_y = {qy[W-1], qy} - {cfg.cy[W-1], cfg.cy};
   assign dx_in  = diff_x[DB-1] ? (DB'(0) - diff_x) : diff_x;
   assign dy_in  = diff_y[DB-1] ? (DB'(0) - diff_y) : diff_y;

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         sqx_ff <= SB'(dx_ff) * SB'(dx_ff);
         sqy_ff <= SB'(dy_ff) * SB'(dy_ff);
         sum_ff <= sqx_ff + sqy_ff;
      end
   end

   // square root, one root bit per stage
   logic [RB-1:0] root_ff [NS];
   logic [SB-1:0] rem_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      localparam int B = RB - 1 - k;
      logic [RB-1:0] root_prev, root_in;
      logic [SB-1:0] rem_prev, rem_in, trial;

      if (k == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = sum_ff;
      end else begin : g_next
         assign root_prev = root_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
      end

      // (r + 2^B)^2 - r^2, with r clear at bit B and below
      assign trial = (SB'(root_prev) << (B + 1)) | (SB'(1) << (2 * B));

      always_comb begin
         root_in = root_prev;
         rem_in  = rem_prev;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (RB'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
         end
      end
   end

   // edge distance, clamped at zero; a circle is active inside its reach
   logic [RB-1:0] root_dist, edge_in;
   logic          act_in;
   logic [W-1:0]  edist_ff;
   logic          eact_ff;

   assign root_dist = root_ff[NS-1];
   assign edge_in   = (root_dist > RB'(cfg.radius)) ? (root_dist - RB'(cfg.radius)) : '0;
   assign act_in    = edge_in < RB'(cfg.reach);

   always_ff @(posedge clock) begin
      if (advance) begin
         edist_ff <= edge_in[W-1:0];
         eact_ff  <= act_in;
      end
   end

   // t = edge * 2^F / reach, one quotient bit per stage; edge < reach
   logic [W-1:0] drem_ff [ND];
   logic [F-1:0] quo_ff  [ND];
   logic         dact_ff [ND];

   for (genvar k = 0; k < ND; k++) begin : g_div
      logic [W-1:0] rem_prev, rem_in;
      logic [F-1:0] quo_prev, quo_in;
      logic         act_prev;
      logic [W:0]   shifted;

      if (k == 0) begin : g_first
         assign rem_prev = edist_ff;
         assign quo_prev = '0;
         assign act_prev = eact_ff;
      end else begin : g_next
         assign rem_prev = drem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign act_prev = dact_ff[k-1];
      end

      assign shifted = {rem_prev, 1'b0};

      always_comb begin
         if (shifted >= {1'b0, cfg.reach}) begin
            rem_in = W'(shifted - {1'b0, cfg.reach});
            quo_in = {quo_prev[F-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_prev[F-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            drem_ff[k] <= rem_in;
            quo_ff[k]  <= quo_in;
            dact_ff[k] <= act_prev;
         end
      end
   end

   // smoothstep weight and blend
   logic [F-1:0]   t_ff, t2_ff, t2b_ff, t3_ff;
   logic           act2_ff, act3_ff, acts_ff, actp_ff;
   logic [2*F-1:0] tt, t2t;
   logic [F+1:0]   s_raw;
   logic [XB-1:0]  s_in, s_ff;
   logic [PB-1:0]  psize_ff, pdflt_ff;
   logic [PB:0]    psum;
   logic [W-1:0]   blend_ff;

   assign tt    = {{F{1'b0}}, quo_ff[ND-1]} * {{F{1'b0}}, quo_ff[ND-1]};
   assign t2t   = {{F{1'b0}}, t2_ff} * {{F{1'b0}}, t_ff};
   assign s_raw = ({2'b00, t2b_ff} << 1) + {2'b00, t2b_ff} - ({2'b00, t3_ff} << 1);
   assign s_in  = (s_raw > (F+2)'(ONE)) ? ONE : s_raw[XB-1:0];
   assign psum  = {1'b0, psize_ff} + {1'b0, pdflt_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff     <= quo_ff[ND-1];
         t2_ff    <= tt[2*F-1:F];
         act2_ff  <= dact_ff[ND-1];
         t2b_ff   <= t2_ff;
         t3_ff    <= t2t[2*F-1:F];
         act3_ff  <= act2_ff;
         s_ff     <= s_in;
         acts_ff  <= act3_ff;
         psize_ff <= PB'(ONE - s_ff) * PB'(cfg.size);
         pdflt_ff <= PB'(s_ff) * PB'(dflt);
         actp_ff  <= acts_ff;
         blend_ff <= actp_ff ? psum[F +: W] : dflt;
      end
   end

   assign blend = blend_ff;

endmodule

FILE: rtl/core/two_circle_mesh_size_field.sv
// Two-circle mesh size field. Each item is a query point (Q16.16 x, y) and
// gives one target element size: the minimum of the default size and, for
// the notch and the hole, a smoothstep blend from the circle's size at its
// edge to the default size at the circle's reach. Inside a circle the blend
// is that circle's size; a circle with zero reach never acts. The pipeline
// takes one item per clock while not stalled and registers each result at
// rsp_mesh_size; the depth comes from the 33-stage square root and the
// 16-stage divider, one result bit per stage, in each of the two circle
// lanes. The whole pipeline holds while a result waits on rsp_ready. Write
// the registers through the csr port only while no item is in flight.
`include "assert_macros.svh"

module two_circle_mesh_size_field_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [31:0]                       req_query_x,
   input  logic signed [31:0]                       req_query_y,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [31:0]                              rsp_mesh_size,
   input  logic                                     csr_we,
   input  logic [tcms_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [tcms_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int W  = tcms_pkg::WORD_BITS;
   localparam int F  = tcms_pkg::FRAC_BITS;
   localparam int H  = tcms_pkg::HALF_BITS;
   localparam int NL = tcms_pkg::LANE_STAGES;
   localparam logic [W-1:0] SIZE_ONE = W'(1) << F;

   // configuration registers
   logic [W-1:0]               default_size_ff;
   tcms_pkg::circle_cfg_type   notch_ff, hole_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_size_ff <= SIZE_ONE;
         notch_ff        <= '{cx: '0, cy: '0, radius: '0, reach: '0, size: SIZE_ONE};
         hole_ff         <= '{cx: '0, cy: '0, radius: '0, reach: '0, size: SIZE_ONE};
      end else if (csr_we) begin
         case (csr_index)
            tcms_pkg::CSR_DEFAULT_SIZE: begin
               default_size_ff <= csr_wdata[W-1:0];
            end
            tcms_pkg::CSR_NOTCH_CENTER: begin
               notch_ff.cx <= csr_wdata[H +: W];
               notch_ff.cy <= csr_wdata[W-1:0];
            end
            tcms_pkg::CSR_NOTCH_RADIUS_REACH: begin
               notch_ff.radius <= csr_wdata[H +: W];
               notch_ff.reach  <= csr_wdata[W-1:0];
            end
            tcms_pkg::CSR_NOTCH_SIZE: begin
               notch_ff.size <= csr_wdata[W-1:0];
            end
            tcms_pkg::CSR_HOLE_CENTER: begin
               hole_ff.cx <= csr_wdata[H +: W];
               hole_ff.cy <= csr_wdata[W-1:0];
            end
            tcms_pkg::CSR_HOLE_RADIUS_REACH: begin
               hole_ff.radius <= csr_wdata[H +: W];
               hole_ff.reach  <= csr_wdata[W-1:0];
            end
            tcms_pkg::CSR_HOLE_SIZE: begin
               hole_ff.size <= csr_wdata[W-1:0];
            end
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   logic                 in_valid_ff;
   logic signed [W-1:0]  qx_ff, qy_ff;
   logic [NL-1:0]        lane_valid_ff;
   logic                 rsp_valid_ff;
   logic [W-1:0]         rsp_size_ff, rsp_size_in;
   logic [W-1:0]         notch_blend, hole_blend, first_min;

   // Advance every stage together unless a finished item is stuck at the
   // output; bubbles travel like items, marked by their valid bit.
   logic advance;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         lane_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         lane_valid_ff <= {lane_valid_ff[NL-2:0], in_valid_ff};
         rsp_valid_ff  <= lane_valid_ff[NL-1];
      end
   end

   // payload: hold on stall, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         qx_ff       <= req_query_x[W-1:0];
         qy_ff       <= req_query_y[W-1:0];
         rsp_size_ff <= rsp_size_in;
      end
   end

   tcms_circle u_notch (
      .clock   (clock),
      .advance (advance),
      .cfg     (notch_ff),
      .dflt    (default_size_ff),
      .qx      (qx_ff),
      .qy      (qy_ff),
      .blend   (notch_blend)
   );

   tcms_circle u_hole (
      .clock   (clock),
      .advance (advance),
      .cfg     (hole_ff),
      .dflt    (default_size_ff),
      .qx      (qx_ff),
      .qy      (qy_ff),
      .blend   (hole_blend)
   );

   // An idle circle already returns the default size, so the minimum of
   // the two lanes and the default is the answer.
   assign first_min   = (notch_blend < default_size_ff) ? notch_blend : default_size_ff;
   assign rsp_size_in = (hole_blend < first_min) ? hole_blend : first_min;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mesh_size = rsp_size_ff;

   `TCMS_ASSERT(a_stall_holds_pipe, clock, reset, !req_ready |=> $stable(lane_valid_ff))
   `TCMS_ASSERT(a_stall_keeps_result, clock, reset, !req_ready |=> rsp_valid)
   `TCMS_ASSERT(a_accept_enters, clock, reset, (req_valid && req_ready) |=> in_valid_ff)
   `TCMS_ASSERT_NR(a_reset_empties, clock, $past(reset) |-> (!rsp_valid && lane_valid_ff == '0))

endmodule

FILE: tb/size_field_checker.sv
module size_field_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [31:0]                   req_query_x,
   input  logic signed [31:0]                   req_query_y,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [31:0]                          rsp_mesh_size,
   input  logic                                 csr_we,
   input  logic [tcms_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tcms_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                   fail_count,
   output int                                   pending_sizes,
   output int                                   checked_sizes
);

   logic [31:0] dflt_q;
   logic [63:0] notch_ctr_q, notch_rr_q, hole_ctr_q, hole_rr_q;
   logic [31:0] notch_size_q, hole_size_q;
   logic [31:0] size_queue[$];

   // floor(sqrt(v)) by digit recurrence, 34 result bits
   function automatic logic [33:0] isqrt(logic [67:0] v);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (34'd1 << b);
         if ({34'd0, c} * {34'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic [31:0] circle_blend(logic signed [31:0] qx, logic signed [31:0] qy,
         logic [63:0] ctr, logic [63:0] rr, logic [31:0] csize, logic [31:0] dflt);
      logic signed [33:0] dx, dy;
      logic [67:0] sq;
      logic [33:0] root_dist, e;
      logic [63:0] t, t2, t3, s, blend;
      dx = 34'(qx) - 34'($signed(ctr[63:32]));
      dy = 34'(qy) - 34'($signed(ctr[31:0]));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
      root_dist = isqrt(sq);
      e = (root_dist > {2'b0, rr[63:32]}) ? root_dist - rr[63:32] : '0;
      if (e >= {2'b0, rr[31:0]}) return dflt;
      t = ({30'd0, e} << tcms_pkg::FRAC_BITS) / rr[31:0];
      t2 = (t * t) >> tcms_pkg::FRAC_BITS;
      t3 = (t2 * t) >> tcms_pkg::FRAC_BITS;
      s = 3 * t2 - 2 * t3;
      if (s > (64'd1 << tcms_pkg::FRAC_BITS)) s = 64'd1 << tcms_pkg::FRAC_BITS;
      blend = (((64'd1 << tcms_pkg::FRAC_BITS) - s) * csize + s * dflt)
              >> tcms_pkg::FRAC_BITS;
      return blend[31:0];
   endfunction

   function automatic logic [31:0] target_size(logic signed [31:0] qx, logic signed [31:0] qy);
      logic [31:0] res, a, b;
      res = dflt_q;
      a = circle_blend(qx, qy, notch_ctr_q, notch_rr_q, notch_size_q, dflt_q);
      b = circle_blend(qx, qy, hole_ctr_q, hole_rr_q, hole_size_q, dflt_q);
      if (a < res) res = a;
      if (b < res) res = b;
      return res;
   endfunction

   assign pending_sizes = size_queue.size();

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         dflt_q <= 32'd65536;
         notch_ctr_q <= '0;
         notch_rr_q <= '0;
         notch_size_q <= 32'd65536;
         hole_ctr_q <= '0;
         hole_rr_q <= '0;
         hole_size_q <= 32'd65536;
         size_queue.delete();
         fail_count <= 0;
         checked_sizes <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tcms_pkg::CSR_DEFAULT_SIZE:       dflt_q <= csr_wdata[31:0];
               tcms_pkg::CSR_NOTCH_CENTER:       notch_ctr_q <= csr_wdata;
               tcms_pkg::CSR_NOTCH_RADIUS_REACH: notch_rr_q <= csr_wdata;
               tcms_pkg::CSR_NOTCH_SIZE:         notch_size_q <= csr_wdata[31:0];
               tcms_pkg::CSR_HOLE_CENTER:        hole_ctr_q <= csr_wdata;
               tcms_pkg::CSR_HOLE_RADIUS_REACH:  hole_rr_q <= csr_wdata;
               tcms_pkg::CSR_HOLE_SIZE:          hole_size_q <= csr_wdata[31:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            size_queue.push_back(target_size(req_query_x, req_query_y));
         if (rsp_valid && rsp_ready) begin
            checked_sizes <= checked_sizes + 1;
            if (size_queue.size() == 0) begin
               $error("unexpected mesh_size: actual %h", rsp_mesh_size);
               fail_count <= fail_count + 1;
            end else begin
               want = size_queue.pop_front();
               if (want !== rsp_mesh_size) begin
                  $error("mesh_size: expected %h actual %h", want, rsp_mesh_size);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;

   localparam int LATENCY = 60;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_query_x = '0;
   logic signed [31:0] req_query_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_mesh_size;
   logic csr_we = 1'b0;
   logic [tcms_pkg::CSR_INDEX_BITS-1:0] csr_index = tcms_pkg::CSR_DEFAULT_SIZE;
   logic [tcms_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   int fail_count, pending_sizes, checked_sizes;
   int cycle_count = 0;
   int sent_points = 0;
   bit long_hold = 1'b0;

   // Circle placement used by the random part; offsets land near the edges.
   logic signed [31:0] aim_x, aim_y;
   logic [31:0] aim_r, aim_reach;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   two_circle_mesh_size_field_core i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_query_x, .req_query_y,
      .rsp_valid, .rsp_ready, .rsp_mesh_size, .csr_we, .csr_index, .csr_wdata
   );

   size_field_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_query_x, .req_query_y,
      .rsp_valid, .rsp_ready, .rsp_mesh_size, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending_sizes, .checked_sizes
   );

   // Bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Receiver: random stall per item, plus one long hold-off that stalls the pipe.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) gap = 0;
         rsp_ready <= (gap == 0);
         repeat (gap) @(negedge clock);
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!(rsp_valid && rsp_ready)) @(negedge clock);
      end
   end

   // Offer one point; hold until accepted at a rising edge.
   task automatic send_point(logic signed [31:0] qx, logic signed [31:0] qy, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_query_x <= qx;
      req_query_y <= qy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_points++;
   endtask

   // Wait for every pending result, then for the pipeline to empty.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_sizes != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_reg(logic [tcms_pkg::CSR_INDEX_BITS-1:0] idx, logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Load a full circle setup with sizes and default.
   task automatic setup_circles(logic [31:0] dflt, logic [63:0] nc, logic [63:0] nrr,
         logic [31:0] ns, logic [63:0] hc, logic [63:0] hrr, logic [31:0] hs);
      write_reg(tcms_pkg::CSR_DEFAULT_SIZE, {32'd0, dflt});
      write_reg(tcms_pkg::CSR_NOTCH_CENTER, nc);
      write_reg(tcms_pkg::CSR_NOTCH_RADIUS_REACH, nrr);
      write_reg(tcms_pkg::CSR_NOTCH_SIZE, {32'd0, ns});
      write_reg(tcms_pkg::CSR_HOLE_CENTER, hc);
      write_reg(tcms_pkg::CSR_HOLE_RADIUS_REACH, hrr);
      write_reg(tcms_pkg::CSR_HOLE_SIZE, {32'd0, hs});
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 4))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   // Point near one of the circles' edges or blend band, else anywhere.
   task automatic random_point(output logic signed [31:0] qx, output logic signed [31:0] qy);
      int span;
      if ($urandom_range(0, 9) < 8) begin
         span = int'(aim_r >> 16) + int'(aim_reach >> 16) + 2;
         qx = aim_x + $signed($urandom_range(0, 2 * span)) * 65536 - span * 65536
              + $signed($urandom_range(0, 65535));
         qy = aim_y + $signed($urandom_range(0, 2 * span)) * 65536 - span * 65536;
      end else begin
         qx = rand_word();
         qy = rand_word();
      end
   endtask

   initial begin
      logic signed [31:0] qx, qy;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: both circles idle, result is the default everywhere.
      send_point(32'sh7fffffff, 32'sh80000000, 0);
      send_point(32'sh80000000, 32'sh7fffffff, 1);
      drain();

      // Notch at the origin with radius 4, reach 8; hole at (10,-10) with radius 2, reach 3.
      setup_circles(32'h0004_0000, 64'd0, {32'h0004_0000, 32'h0008_0000}, 32'h0000_8000,
                    {32'h000a_0000, 32'hfff6_0000}, {32'h0002_0000, 32'h0003_0000},
                    32'h0000_4000);
      send_point(32'sh0, 32'sh0, 0);                       // inside the notch
      send_point(32'sh0004_0000, 32'sh0, 0);               // on the notch edge
      send_point(32'sh0008_0000, 32'sh0, 0);               // mid blend
      send_point(32'sh000c_0000, 32'sh0, 0);               // exactly at reach
      send_point(32'sh000a_0000, 32'shfff6_0000, 0);       // hole centre
      send_point(32'sh000b_8000, 32'shfff6_0000, 2);       // inside the hole
      send_point(32'sh7fffffff, 32'sh7fffffff, 0);         // far corner
      send_point(32'sh80000000, 32'sh80000000, 0);         // opposite corner
      send_point(32'sh0003_0000, 32'sh0003_0000, 3);
      drain();

      // Extremes: centres at the word limits, sizes and reaches at zero, one or full scale.
      setup_circles(32'hffffffff, {32'h7fffffff, 32'h80000000}, {32'h0, 32'hffffffff},
                    32'h0, {32'h80000000, 32'h7fffffff}, {32'hffffffff, 32'h0000_0001},
                    32'hffffffff);
      send_point(32'sh80000000, 32'sh7fffffff, 0);
      send_point(32'sh7fffffff, 32'sh80000000, 0);
      send_point(32'sh0, 32'sh0, 0);
      send_point(32'sh80000000, 32'sh80000000, 0);
      send_point(32'sh7fffffff, 32'sh7fffffff, 0);
      drain();

      // Zero reach with a huge radius: never active even inside.
      setup_circles(32'h0001_0000, 64'd0, {32'hffffffff, 32'h0}, 32'h0,
                    64'd0, {32'h0, 32'h0}, 32'h0);
      send_point(32'sh0, 32'sh0, 0);
      send_point(32'sh0001_0000, 32'sh0, 0);
      drain();

      // Random phases with fresh random settings and small circle geometry.
      for (int ph = 0; ph < 6; ph++) begin
         aim_x = $signed($urandom_range(0, 64)) * 65536 - 32 * 65536;
         aim_y = $signed($urandom_range(0, 64)) * 65536 - 32 * 65536;
         aim_r = $urandom_range(0, 8 * 65536);
         aim_reach = (ph == 5) ? 32'h0 : $urandom_range(1, 16 * 65536);
         setup_circles(ph == 0 ? 32'hffffffff : $urandom,
                       {aim_x, aim_y}, {aim_r, aim_reach},
                       ph == 1 ? 32'h0 : $urandom,
                       {aim_x + 32'sh0003_0000, aim_y - 32'sh0002_0000},
                       {$urandom_range(0, 4 * 65536), 32'($urandom_range(0, 12 * 65536))},
                       $urandom);
         if (ph == 4) write_reg(tcms_pkg::CSR_UNUSED_INDEX, 64'hffff_ffff_ffff_ffff);
         for (int n = 0; n < 120; n++) begin
            random_point(qx, qy);
            if (ph == 2 && n == 10) long_hold = 1'b1;
            send_point(qx, qy, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
            if (ph == 3 && n == 60) drain();   // sender waits for every result
         end
         drain();
      end

      $display("Covered %0d query points and %0d checked sizes over 10 register setups,",
               sent_points, checked_sizes);
      $display("including edge, inside, reach, zero-reach and word-limit cases.");
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tcms_pkg.sv
rtl/core/tcms_circle.sv
rtl/core/two_circle_mesh_size_field.sv
tb/size_field_checker.sv
tb/tb_top.sv
